// ----- rtl/rms_level_meter_db_defines.svh -----
// Assertion helpers shared by the RTL of the level meter.
// All checks sample on the rising edge of clk.
`ifndef RMS_LEVEL_METER_DB_DEFINES_SVH
`define RMS_LEVEL_METER_DB_DEFINES_SVH

// Check that is ignored while rst is high.
`define RLM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that holds during reset too.
`define RLM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/rlm_pkg.sv -----
`timescale 1ns / 1ps
package rlm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_FRAME   = 1024;
  localparam int CNT_W       = $clog2(MAX_FRAME + 1);
  localparam int ENERGY_W    = 40;
  localparam int MUL_W       = 31;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int FRAC_BITS   = 16;
  localparam int EXP_W       = 6;
  localparam int LG_W        = EXP_W + FRAC_BITS;
  localparam int LEVEL_W     = 16;

  localparam logic [CNT_W-1:0]   FRAME_LIMIT       = CNT_W'(MAX_FRAME);
  localparam logic [MUL_W-1:0]   DB_PER_OCTAVE_Q16 = MUL_W'(197283);
  localparam logic [LEVEL_W-1:0] LEVEL_FLOOR       = 16'h8000;

  // Control into and status out of the normalizer.
  typedef struct packed {
    logic                start;
    logic [ENERGY_W-1:0] x;
  } norm_ctl_t;

  typedef struct packed {
    logic             done;
    logic [EXP_W-1:0] expo;
    logic [MUL_W-1:0] mant;
  } norm_stat_t;

endpackage

// ----- rtl/rlm_mult.sv -----
`timescale 1ns / 1ps
module rlm_mult (
  input  logic                       clk,
  input  logic [rlm_pkg::MUL_W-1:0]  a,
  input  logic [rlm_pkg::MUL_W-1:0]  b,
  output logic [rlm_pkg::PROD_W-1:0] prod
);
  import rlm_pkg::*;

  // One registered unsigned multiply, shared by squares, log2 and dB steps.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ----- rtl/rlm_norm.sv -----
`timescale 1ns / 1ps
module rlm_norm (
  input  logic                clk,
  input  logic                rst,
  input  rlm_pkg::norm_ctl_t  ctl,
  output rlm_pkg::norm_stat_t stat
);
  import rlm_pkg::*;

  logic                busy;
  logic [ENERGY_W-1:0] mreg;
  logic [EXP_W-1:0]    expo;
  logic                high;
  logic                settled;

  // The value is settled once its top set bit sits at bit MUL_W-1 (Q1.30).
  assign high    = |mreg[ENERGY_W-1:MUL_W];
  assign settled = !high && mreg[MUL_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.start) begin
      busy <= 1'b1;
    end else if (busy && settled) begin
      busy <= 1'b0;
    end
  end

  // One bit position per cycle; right shifts truncate.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mreg <= ctl.x;
      expo <= EXP_W'(MUL_W - 1);
    end else if (busy && !settled) begin
      if (high) begin
        mreg <= mreg >> 1;
        expo <= expo + 1'b1;
      end else begin
        mreg <= mreg << 1;
        expo <= expo - 1'b1;
      end
    end
  end

  assign stat.done = busy && settled;
  assign stat.expo = expo;
  assign stat.mant = mreg[MUL_W-1:0];

endmodule

// ----- rtl/rms_level_meter_db.sv -----
`timescale 1ns / 1ps
// Flow: a sample without tlast is squared and then accumulated before the next one is taken.
// A frame end gives its level after two bit-serial normalizations and two 16-round log2 loops
// on one shared 31x31 multiplier; a silent frame skips them.
// No new sample is taken until the level of a frame end has moved to the output register,
// and a stalled output holds the sequencer until the level is taken.
// Reset: rst is synchronous and active high; it clears the energy, the count and the output.
`include "rms_level_meter_db_defines.svh"
module rms_level_meter_db (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  input  logic        s_tlast,   // frame_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] level_db
  output logic        m_tuser    // level_status
);
  import rlm_pkg::*;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQR  = 4'd1;
  localparam logic [3:0] ST_ACC  = 4'd2;
  localparam logic [3:0] ST_NORM = 4'd3;
  localparam logic [3:0] ST_LMUL = 4'd4;
  localparam logic [3:0] ST_LRND = 4'd5;
  localparam logic [3:0] ST_DIFF = 4'd6;
  localparam logic [3:0] ST_DMUL = 4'd7;
  localparam logic [3:0] ST_DRND = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  localparam int SUM_W = ENERGY_W + 1;
  localparam int D_W   = LG_W + 2;
  localparam int RND_W = 42;
  localparam int Q_W   = RND_W - 24;
  // Full scale squared, as log2 in Q.16: 2*(SAMPLE_BITS-1) octaves.
  localparam logic [D_W-1:0]   FS_LG2_Q16 = D_W'(2 * (SAMPLE_BITS - 1) * (1 << FRAC_BITS));
  localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(1) << 23;

  logic [3:0]          state;
  logic [ENERGY_W-1:0] energy_sum;
  logic [CNT_W-1:0]    sample_count;
  logic [CNT_W-1:0]    hold_count;
  logic                last_r;
  logic                phase;      // 0 while taking log2 of the energy, 1 for the count
  logic [3:0]          rnd;
  logic [FRAC_BITS-1:0] frac;
  logic [EXP_W-1:0]    exp_r;
  logic [LG_W-1:0]     lg_e;
  logic [LG_W-1:0]     lg_c;
  logic [MUL_W-1:0]    op_a;
  logic [MUL_W-1:0]    op_b;
  logic [PROD_W-1:0]   prod;
  logic [LEVEL_W-1:0]  res_level;
  logic                res_status;

  logic [15:0]          sample_mag;
  logic                 keep;
  logic [SUM_W-1:0]     e_sum;
  logic [ENERGY_W-1:0]  e_new;
  logic [CNT_W-1:0]     c_new;
  logic [MUL_W:0]       sq;
  logic                 sq_bit;
  logic [FRAC_BITS-1:0] frac_next;
  logic [D_W-1:0]       d;
  logic [D_W-1:0]       mag;
  logic [RND_W-1:0]     rnd_sum;
  logic [Q_W-1:0]       q;
  logic                 accept;
  logic                 out_load;
  norm_ctl_t            norm_ctl;
  norm_stat_t           norm_stat;

  // The magnitude of -32768 is 0x8000, which is correct as an unsigned value.
  assign sample_mag = s_tdata[15] ? (~s_tdata + 16'd1) : s_tdata;
  assign accept     = s_tvalid && s_tready;
  assign s_tready   = (state == ST_IDLE);

  // Samples past the frame limit are dropped, but tlast still closes the frame.
  assign keep  = sample_count < FRAME_LIMIT;
  assign e_sum = SUM_W'(energy_sum) + SUM_W'(prod[MUL_W-1:0]);
  assign e_new = !keep ? energy_sum :
                 (e_sum[ENERGY_W] ? {ENERGY_W{1'b1}} : e_sum[ENERGY_W-1:0]);
  assign c_new = keep ? sample_count + 1'b1 : sample_count;

  // One log2 fraction round: square the Q1.30 mantissa and renormalize to [1, 2).
  assign sq        = prod[PROD_W-1:MUL_W-1];
  assign sq_bit    = sq[MUL_W];
  assign frac_next = {frac[FRAC_BITS-2:0], sq_bit};

  // Level in octaves below full scale, then scaled to decibels with rounding.
  assign d       = D_W'(lg_e) - D_W'(lg_c) - FS_LG2_Q16;
  assign mag     = -d;
  assign rnd_sum = prod[RND_W-1:0] + ROUND_HALF;
  assign q       = rnd_sum[RND_W-1:24];

  // The shared multiplier squares op_a except while scaling by dB per octave.
  assign op_b = (state == ST_DMUL) ? DB_PER_OCTAVE_Q16 : op_a;

  rlm_mult u_mult (
    .clk  (clk),
    .a    (op_a),
    .b    (op_b),
    .prod (prod)
  );

  always_comb begin
    norm_ctl.start = 1'b0;
    norm_ctl.x     = ENERGY_W'(hold_count);
    if (state == ST_ACC) begin
      norm_ctl.start = last_r && (e_new != '0);
      norm_ctl.x     = e_new;
    end else if (state == ST_LRND) begin
      norm_ctl.start = (rnd == 4'd15) && !phase;
    end
  end

  rlm_norm u_norm (
    .clk  (clk),
    .rst  (rst),
    .ctl  (norm_ctl),
    .stat (norm_stat)
  );

  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  // Sequencer and frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      energy_sum   <= '0;
      sample_count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SQR;
          end
        end
        ST_SQR: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (!last_r) begin
            energy_sum   <= e_new;
            sample_count <= c_new;
            state        <= ST_IDLE;
          end else begin
            energy_sum   <= '0;
            sample_count <= '0;
            state        <= (e_new == '0) ? ST_DONE : ST_NORM;
          end
        end
        ST_NORM: begin
          if (norm_stat.done) begin
            state <= ST_LMUL;
          end
        end
        ST_LMUL: begin
          state <= ST_LRND;
        end
        ST_LRND: begin
          if (rnd != 4'd15) begin
            state <= ST_LMUL;
          end else begin
            state <= phase ? ST_DIFF : ST_NORM;
          end
        end
        ST_DIFF: begin
          state <= d[D_W-1] ? ST_DMUL : ST_DONE;
        end
        ST_DMUL: begin
          state <= ST_DRND;
        end
        ST_DRND: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op_a   <= MUL_W'(sample_mag);
        last_r <= s_tlast;
      end
      ST_ACC: begin
        hold_count <= c_new;
        phase      <= 1'b0;
        res_level  <= LEVEL_FLOOR;
        res_status <= 1'b1;
      end
      ST_NORM: begin
        op_a  <= norm_stat.mant;
        exp_r <= norm_stat.expo;
        rnd   <= '0;
        frac  <= '0;
      end
      ST_LRND: begin
        op_a <= sq_bit ? sq[MUL_W:1] : sq[MUL_W-1:0];
        frac <= frac_next;
        rnd  <= rnd + 1'b1;
        if (rnd == 4'd15) begin
          if (phase) begin
            lg_c <= {exp_r, frac_next};
          end else begin
            lg_e  <= {exp_r, frac_next};
            phase <= 1'b1;
          end
        end
      end
      ST_DIFF: begin
        op_a       <= MUL_W'(mag);
        res_level  <= '0;
        res_status <= 1'b0;
      end
      ST_DRND: begin
        if (|q[Q_W-1:15]) begin
          res_level <= LEVEL_FLOOR;
        end else begin
          res_level <= -{1'b0, q[14:0]};
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: the input side is free again while a level waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= res_level;
      m_tuser <= res_status;
    end
  end

  `RLM_ASSERT(a_count_bound, sample_count <= FRAME_LIMIT, "sample count passed the frame limit")
  `RLM_ASSERT(a_level_not_positive, m_tvalid |-> (m_tdata[15] || m_tdata == 16'd0), "level above 0 dBFS")
  `RLM_ASSERT(a_silent_floor, (m_tvalid && m_tuser) |-> (m_tdata == LEVEL_FLOOR), "silent frame not at floor")
  `RLM_ASSERT(a_round_exp, (state == ST_LRND) |-> (exp_r < EXP_W'(ENERGY_W)), "log2 exponent out of range")
  `RLM_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> (state == ST_IDLE && !m_tvalid), "not idle after reset")

endmodule

// ----- verif/tb_rms_level_meter_db.sv -----
`timescale 1ns / 1ps
module tb_rms_level_meter_db;

  // Packed result as it leaves the meter: level in Q8.8 dBFS plus the silent flag.
  typedef struct packed {
    logic [15:0] level_db;
    logic        level_status;
  } level_result_t;

  // Ways of filling a frame with samples.
  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_QUIET,
    SHAPE_SILENT,
    SHAPE_LOUD,
    SHAPE_MIXED
  } frame_shape_e;

  // Idling phases of the run.
  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // 10*log10(2) in Q.16; multiplying an octave count in Q.16 by it gives dB in Q.32.
  localparam longint unsigned DB_OCTAVE_Q16 = 197283;
  localparam logic [63:0]     ENERGY_CEIL   = (64'd1 << 40) - 64'd1;
  localparam logic [15:0]     LEVEL_BOTTOM  = 16'h8000;

  // Tracks the frame energy and sample count the way the meter should, and keeps
  // the levels that are still owed by the design in arrival order.
  class level_scoreboard;
    logic [63:0]   energy;
    int unsigned   count;
    level_result_t level_q[$];
    int            errors;

    function new();
      energy = 0;
      count  = 0;
      errors = 0;
    endfunction

    task report_mismatch(input string msg);
      if (errors < 20) $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    // log2 in unsigned Q.16: integer part from the top set bit, fraction from
    // sixteen rounds of squaring a Q1.30 mantissa, truncating throughout.
    function logic [63:0] lg_fixed(input logic [63:0] x);
      int          top;
      logic [63:0] mant;
      logic [63:0] frac;
      top = 0;
      for (int b = 0; b < 64; b++) if (x[b]) top = b;
      mant = (top >= 30) ? (x >> (top - 30)) : (x << (30 - top));
      frac = 0;
      repeat (16) begin
        mant = (mant * mant) >> 30;
        frac = frac << 1;
        if (mant >= 64'h8000_0000) begin
          mant    = mant >> 1;
          frac[0] = 1'b1;
        end
      end
      return (64'(top) << 16) | frac;
    endfunction

    function level_result_t frame_level();
      level_result_t   res;
      longint          diff;
      longint unsigned mag;
      longint unsigned q;
      if (energy == 0) begin
        res.level_db     = LEVEL_BOTTOM;
        res.level_status = 1'b1;
        return res;
      end
      res.level_status = 1'b0;
      diff = longint'(lg_fixed(energy)) - longint'(lg_fixed(64'(count)))
           - longint'(2 * (rlm_pkg::SAMPLE_BITS - 1)) * 65536;
      if (diff >= 0) begin
        res.level_db = 16'h0000;
      end else begin
        mag = longint'(-diff);
        q   = (mag * DB_OCTAVE_Q16 + (64'd1 << 23)) >> 24;
        res.level_db = (q >= 32768) ? LEVEL_BOTTOM : 16'(-longint'(q));
      end
      return res;
    endfunction

    // One accepted sample: square and accumulate unless the frame is full,
    // and owe a level when it closes the frame.
    function void note_sample(input logic [15:0] smp, input logic last);
      int          v;
      logic [63:0] sq;
      v = int'($signed(smp));
      if (count < rlm_pkg::MAX_FRAME) begin
        sq     = 64'(longint'(v) * longint'(v));
        energy = energy + sq;
        if (energy > ENERGY_CEIL) energy = ENERGY_CEIL;
        count++;
      end
      if (last) begin
        level_q.push_back(frame_level());
        energy = 0;
        count  = 0;
      end
    endfunction

    task check_level(input logic [15:0] lvl, input logic status);
      level_result_t want;
      if (level_q.size() == 0) begin
        report_mismatch($sformatf("level %h status %b with no frame outstanding", lvl, status));
        return;
      end
      want = level_q.pop_front();
      if (lvl !== want.level_db)
        report_mismatch($sformatf("level_db got %h want %h", lvl, want.level_db));
      if (status !== want.level_status)
        report_mismatch($sformatf("level_status got %b want %b", status, want.level_status));
    endtask
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = 16'h0000;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [15:0] m_tdata;
  logic        m_tuser;

  level_scoreboard sb = new();

  // Percent chance per cycle that the sample source holds back or that the
  // level sink refuses a transfer; changed from phase to phase.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned samples_sent   = 0;

  rms_level_meter_db uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The sink draws a fresh ready each cycle, so stalls land on any state of the
  // meter, including the cycles where a level is already waiting.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every level transfer is checked against the oldest outstanding frame.
  // Outputs are read in the active region of the edge, so they hold the values
  // that the edge itself sampled.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_level(m_tdata, m_tuser);
  end

  task set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 65; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 65; end
      default:   begin send_idle_pct = 8;  recv_stall_pct = 8;  end
    endcase
  endtask

  // Offers one sample and returns at the edge where it was taken. The valid is
  // only lowered when an idle gap is drawn, so back-to-back samples keep it high.
  task send_sample(input logic [15:0] smp, input logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_sample(smp, last);
    samples_sent++;
  endtask

  function logic [15:0] pick_sample(input frame_shape_e shape);
    int unsigned sel;
    case (shape)
      SHAPE_QUIET:  return 16'(int'($urandom_range(0, 8)) - 4);
      SHAPE_SILENT: return 16'h0000;
      SHAPE_LOUD: begin
        sel = $urandom_range(0, 3);
        if (sel == 0) return 16'h8000;
        if (sel == 1) return 16'h7FFF;
        if (sel == 2) return 16'h8001;
        return 16'(int'($urandom_range(0, 4095)) + 28672);
      end
      SHAPE_MIXED: begin
        sel = $urandom_range(0, 2);
        if (sel == 0) return 16'(int'($urandom_range(0, 2047)) - 1024);
        if (sel == 1) return 16'h0000;
        return 16'($urandom_range(0, 65535));
      end
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task send_frame(input int len, input frame_shape_e shape);
    for (int i = 0; i < len; i++) send_sample(pick_sample(shape), i == len - 1);
  endtask

  // Stops offering samples, waits until every owed level has come back, then
  // lets the frame-end pipeline run dry.
  task drain_levels();
    s_tvalid <= 1'b0;
    while (sb.level_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  initial begin
    frame_shape_e shape;
    int           len;
    int unsigned  phase_start;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames. A lone negative full-scale sample sits exactly at 0 dBFS;
    // a lone zero is a silent frame; a lone +/-1 is the smallest nonzero energy.
    set_idling(IDLE_NONE);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0001, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h4000, 1'b0);
    send_sample(16'hC000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h00FF, 1'b0);
    send_sample(16'hFF00, 1'b0);
    send_sample(16'h1234, 1'b1);
    drain_levels();

    // Random frames, mostly short so that frame ends are frequent, in each
    // idling phase. Each phase ends on a frame boundary and drains.
    for (int ph = IDLE_NONE; ph <= IDLE_BOTH; ph++) begin
      set_idling(idle_mode_e'(ph));
      phase_start = samples_sent;
      while (samples_sent - phase_start < 155) begin
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        shape = frame_shape_e'($urandom_range(SHAPE_RANDOM, SHAPE_MIXED));
        send_frame(len, shape);
      end
      drain_levels();
    end

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Backstop: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
